@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same, on the usual clk_i and rst_ni
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ rtl/bprc_pkg.sv @@
package bprc_pkg;

  localparam int unsigned MaxSlotsDef     = 16;
  localparam int unsigned PointerWidthDef = 32;
  localparam int unsigned RingSizeW       = 5;
  localparam int unsigned RingSizeReset   = 16;
  localparam int unsigned ReqW            = 3;
  localparam int unsigned IndexW          = 4;
  localparam int unsigned StatusW         = 3;
  localparam int unsigned CountW          = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD       = 3'd0,
    REQ_WR_CLAIM   = 3'd1,
    REQ_WR_COMMIT  = 3'd2,
    REQ_WR_CANCEL  = 3'd3,
    REQ_RD_CLAIM   = 3'd4,
    REQ_RD_RELEASE = 3'd5,
    REQ_RD_CANCEL  = 3'd6
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_FULL       = 3'd2,
    ST_LOCKED     = 3'd3,
    ST_NOT_LOCKED = 3'd4
  } status_e;

  // memory port control from the slot controller
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // per-transfer outcome, registered at the top level
  typedef struct packed {
    status_e status;
    logic    claim_ok;
  } result_t;

endpackage

@@ rtl/bprc_ptr_mem.sv @@
module bprc_ptr_mem
  import bprc_pkg::*;
#(
  parameter int unsigned DEPTH = MaxSlotsDef,
  parameter int unsigned WIDTH = PointerWidthDef,
  parameter int unsigned AW    = $clog2(MaxSlotsDef)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bprc_ctrl.sv @@
module bprc_ctrl
  import bprc_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MaxSlotsDef,
  parameter int unsigned PW        = $clog2(MaxSlotsDef),
  parameter int unsigned CW        = $clog2(MaxSlotsDef + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ring_size_we_i,
  input  logic [RingSizeW-1:0] ring_size_i,
  input  logic                 accept_i,
  input  logic [ReqW-1:0]      req_type_i,
  input  logic [IndexW-1:0]    slot_index_i,
  output logic                 busy_o,
  output mem_ctl_t             mem_ctl_o,
  output logic [PW-1:0]        mem_addr_o,
  output result_t              result_o,
  output logic [CW-1:0]        rd_cnt_o,
  output logic [CW-1:0]        wr_cnt_o
);

  localparam int unsigned AW = (CW > RingSizeW) ? CW : RingSizeW;
  localparam int unsigned ResetActive =
    (RingSizeReset > MAX_SLOTS) ? MAX_SLOTS : RingSizeReset;
  localparam logic [PW-1:0] LastSlot = PW'(MAX_SLOTS - 1);

  typedef enum logic {S_IDLE, S_COUNT} state_e;

  state_e                 state_q, state_d;
  logic [RingSizeW-1:0]   ring_size_q, ring_size_d;
  logic [MAX_SLOTS-1:0]   full_q, full_d, lock_q, lock_d;
  logic [PW-1:0]          wr_pos_q, wr_pos_d, rd_pos_q, rd_pos_d;
  logic [CW-1:0]          rd_cnt_q, rd_cnt_d, wr_cnt_q, wr_cnt_d;
  logic [PW-1:0]          sw_idx_q, sw_idx_d;
  logic [CW-1:0]          acc_rd_q, acc_rd_d, acc_wr_q, acc_wr_d;

  logic [AW-1:0]          active;
  logic [AW-1:0]          rs_ext;
  logic [AW-1:0]          idx_ext;
  logic                   idx_ok;
  logic [PW-1:0]          slot;
  logic                   slot_hit;
  logic                   in_ring;
  logic                   f_old, l_old, f_new, l_new;
  logic                   rd_old, rd_new, wr_old, wr_new;
  logic [PW-1:0]          adv_wr, adv_rd;
  logic [PW:0]            wr_inc, rd_inc;
  logic                   sw_in, sw_rd, sw_wr;
  status_e                status;
  logic                   claim;

  // ring size as used: zero acts as one, clamp to the slot count
  always_comb begin
    rs_ext = AW'(ring_size_q);
    if (ring_size_q == '0) begin
      active = AW'(1);
    end else if (rs_ext > AW'(MAX_SLOTS)) begin
      active = AW'(MAX_SLOTS);
    end else begin
      active = rs_ext;
    end
  end

  assign idx_ext = AW'(slot_index_i);
  assign idx_ok  = idx_ext < AW'(MAX_SLOTS);

  // position advance wraps once past the last slot of the ring
  assign wr_inc = {1'b0, wr_pos_q} + (PW + 1)'(1);
  assign rd_inc = {1'b0, rd_pos_q} + (PW + 1)'(1);
  assign adv_wr = (AW'(wr_inc) >= active) ? '0 : wr_inc[PW-1:0];
  assign adv_rd = (AW'(rd_inc) >= active) ? '0 : rd_inc[PW-1:0];

  always_comb begin
    slot     = wr_pos_q;
    slot_hit = 1'b1;
    unique case (req_type_i) inside
      REQ_LOAD: begin
        slot     = idx_ext[PW-1:0];
        slot_hit = idx_ok;
      end
      REQ_RD_CLAIM, REQ_RD_RELEASE, REQ_RD_CANCEL: begin
        slot = rd_pos_q;
      end
      REQ_WR_CLAIM, REQ_WR_COMMIT, REQ_WR_CANCEL: begin
        slot = wr_pos_q;
      end
      default: begin
        slot_hit = 1'b0;
      end
    endcase
  end

  assign f_old = full_q[slot];
  assign l_old = lock_q[slot];

  always_comb begin
    f_new    = f_old;
    l_new    = l_old;
    status   = ST_OK;
    claim    = 1'b0;
    wr_pos_d = wr_pos_q;
    rd_pos_d = rd_pos_q;
    unique case (req_type_i) inside
      REQ_LOAD: begin
        f_new    = 1'b0;
        l_new    = 1'b0;
        wr_pos_d = '0;
        rd_pos_d = '0;
      end
      REQ_WR_CLAIM: begin
        if (f_old) begin
          status = ST_FULL;
        end else if (l_old) begin
          status = ST_LOCKED;
        end else begin
          l_new = 1'b1;
          claim = 1'b1;
        end
      end
      REQ_WR_COMMIT: begin
        if (!l_old) begin
          status = ST_NOT_LOCKED;
        end else begin
          f_new    = 1'b1;
          l_new    = 1'b0;
          wr_pos_d = adv_wr;
        end
      end
      REQ_RD_CLAIM: begin
        if (!f_old) begin
          status = ST_EMPTY;
        end else if (l_old) begin
          status = ST_LOCKED;
        end else begin
          l_new = 1'b1;
          claim = 1'b1;
        end
      end
      REQ_RD_RELEASE: begin
        if (!l_old) begin
          status = ST_NOT_LOCKED;
        end else begin
          f_new    = 1'b0;
          l_new    = 1'b0;
          rd_pos_d = adv_rd;
        end
      end
      REQ_WR_CANCEL, REQ_RD_CANCEL: begin
        if (!l_old) begin
          status = ST_NOT_LOCKED;
        end else begin
          l_new = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // counts move by the change of the one slot touched, if it lies in the ring
  assign in_ring = slot_hit && (AW'(slot) < active);
  assign rd_old  = in_ring & f_old & ~l_old;
  assign rd_new  = in_ring & f_new & ~l_new;
  assign wr_old  = in_ring & ~f_old & ~l_old;
  assign wr_new  = in_ring & ~f_new & ~l_new;

  // recount sweep terms
  assign sw_in = AW'(sw_idx_q) < active;
  assign sw_rd = sw_in & full_q[sw_idx_q] & ~lock_q[sw_idx_q];
  assign sw_wr = sw_in & ~full_q[sw_idx_q] & ~lock_q[sw_idx_q];

  always_comb begin
    state_d     = state_q;
    ring_size_d = ring_size_q;
    full_d      = full_q;
    lock_d      = lock_q;
    rd_cnt_d    = rd_cnt_q;
    wr_cnt_d    = wr_cnt_q;
    sw_idx_d    = sw_idx_q;
    acc_rd_d    = acc_rd_q;
    acc_wr_d    = acc_wr_q;
    if (ring_size_we_i) begin
      // new ring size: counts are rebuilt by a sweep over all slots
      ring_size_d = ring_size_i;
      state_d     = S_COUNT;
      sw_idx_d    = '0;
      acc_rd_d    = '0;
      acc_wr_d    = '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept_i && slot_hit) begin
            full_d[slot] = f_new;
            lock_d[slot] = l_new;
            rd_cnt_d = rd_cnt_q + CW'(rd_new) - CW'(rd_old);
            wr_cnt_d = wr_cnt_q + CW'(wr_new) - CW'(wr_old);
          end
        end
        S_COUNT: begin
          acc_rd_d = acc_rd_q + CW'(sw_rd);
          acc_wr_d = acc_wr_q + CW'(sw_wr);
          sw_idx_d = sw_idx_q + PW'(1);
          if (sw_idx_q == LastSlot) begin
            rd_cnt_d = acc_rd_d;
            wr_cnt_d = acc_wr_d;
            state_d  = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_size_q <= RingSizeW'(RingSizeReset);
      full_q      <= '0;
      lock_q      <= '0;
      wr_pos_q    <= '0;
      rd_pos_q    <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= CW'(ResetActive);
      sw_idx_q    <= '0;
      acc_rd_q    <= '0;
      acc_wr_q    <= '0;
    end else begin
      state_q     <= state_d;
      ring_size_q <= ring_size_d;
      full_q      <= full_d;
      lock_q      <= lock_d;
      rd_cnt_q    <= rd_cnt_d;
      wr_cnt_q    <= wr_cnt_d;
      sw_idx_q    <= sw_idx_d;
      acc_rd_q    <= acc_rd_d;
      acc_wr_q    <= acc_wr_d;
      if (accept_i) begin
        wr_pos_q <= wr_pos_d;
        rd_pos_q <= rd_pos_d;
      end
    end
  end

  assign busy_o            = (state_q == S_COUNT);
  assign mem_ctl_o.we      = accept_i && (req_type_i == REQ_LOAD) && idx_ok;
  assign mem_ctl_o.re      = accept_i && claim;
  assign mem_addr_o        = slot;
  assign result_o.status   = status;
  assign result_o.claim_ok = claim;
  assign rd_cnt_o          = rd_cnt_q;
  assign wr_cnt_o          = wr_cnt_q;

endmodule

@@ rtl/buffer_pointer_ring_with_claims.sv @@
// channel   direction  handshake               payload
// request   in         start high, busy low    req_type_i slot_index_i pointer_value_i
// result    out        done_o one-cycle strobe status_o buffer_pointer_o
//                                              readable_count_o writable_count_o
// config    in         ring_size_we_i          ring_size_i
//
// one request per cycle while busy is low; its result strobes on done_o in the next cycle
// the pointer comes from the slot memory, a synchronous read on a claim
// a ring size write starts a recount sweep over all MAX_SLOTS slots with busy high
// reset clears flags, positions, readable count; writable = active slots; no sweep
// the receiver cannot stall: status and pointer hold until the next accepted request
module buffer_pointer_ring_with_claims
  import bprc_pkg::*;
#(
  parameter int unsigned MAX_SLOTS     = MaxSlotsDef,
  parameter int unsigned POINTER_WIDTH = PointerWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic [IndexW-1:0]        slot_index_i,
  input  logic [POINTER_WIDTH-1:0] pointer_value_i,
  output logic                     done_o,
  output logic [StatusW-1:0]       status_o,
  output logic [POINTER_WIDTH-1:0] buffer_pointer_o,
  output logic [CountW-1:0]        readable_count_o,
  output logic [CountW-1:0]        writable_count_o,
  input  logic                     ring_size_we_i,
  input  logic [RingSizeW-1:0]     ring_size_i
);

  localparam int unsigned PW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  logic                     accept;
  mem_ctl_t                 mem_ctl;
  logic [PW-1:0]            mem_addr;
  logic [POINTER_WIDTH-1:0] mem_rdata;
  result_t                  result;
  logic [CW-1:0]            rd_cnt, wr_cnt;
  logic                     done_q;
  result_t                  result_q;

  assign accept = start && !busy;

  bprc_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .PW        (PW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ring_size_we_i (ring_size_we_i),
    .ring_size_i    (ring_size_i),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .slot_index_i   (slot_index_i),
    .busy_o         (busy),
    .mem_ctl_o      (mem_ctl),
    .mem_addr_o     (mem_addr),
    .result_o       (result),
    .rd_cnt_o       (rd_cnt),
    .wr_cnt_o       (wr_cnt)
  );

  bprc_ptr_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (POINTER_WIDTH),
    .AW    (PW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (pointer_value_i),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      result_q <= '{status: ST_OK, claim_ok: 1'b0};
    end else begin
      done_q <= accept;
      if (accept) begin
        result_q <= result;
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = result_q.status;
  // pointer only on a successful claim
  assign buffer_pointer_o = result_q.claim_ok ? mem_rdata : '0;
  assign readable_count_o = CountW'(rd_cnt);
  assign writable_count_o = CountW'(wr_cnt);

endmodule

@@ rtl/bprc_checker.sv @@
`include "assert_macros.svh"

module bprc_checker
  import bprc_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [ReqW-1:0]            req_type_i,
  input logic                       done_o,
  input logic [StatusW-1:0]         status_o,
  input logic [PointerWidthDef-1:0] buffer_pointer_o,
  input logic                       ring_size_we_i
);

  `ASSERT_STD(a_done_follows_transfer, (start && !busy) |=> done_o)
  `ASSERT_STD(a_no_spurious_done, !(start && !busy) |=> !done_o)
  `ASSERT_STD(a_ptr_zero_on_fail, (done_o && status_o != ST_OK) |-> buffer_pointer_o == '0)
  `ASSERT_STD(a_load_ok, (done_o && $past(req_type_i) == REQ_LOAD) |-> status_o == ST_OK)
  `ASSERT_STD(a_ring_write_busy, ring_size_we_i |=> busy)

endmodule

bind buffer_pointer_ring_with_claims bprc_checker u_bprc_checker (.*);

@@ tb/buffer_pointer_ring_with_claims_tb.sv @@
module buffer_pointer_ring_with_claims_tb;
  import bprc_pkg::*;

  localparam int unsigned PtrW       = PointerWidthDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 120;
  localparam int unsigned NumPhases  = 10;
  localparam logic [ReqW-1:0] ReqUnused = 3'd7;

  typedef struct {
    status_e             status;
    logic [PtrW-1:0]     ptr;
    logic [CountW-1:0]   readable;
    logic [CountW-1:0]   writable;
  } ring_result_t;

  class ring_claim_model;
    logic [PtrW-1:0]        slot_ptr [MaxSlotsDef];
    logic [MaxSlotsDef-1:0] full_q;
    logic [MaxSlotsDef-1:0] lock_q;
    logic [IndexW-1:0]      wr_pos;
    logic [IndexW-1:0]      rd_pos;
    logic [RingSizeW-1:0]   ring_size;
    ring_result_t           pending[$];
    int unsigned            errors;

    function new();
      foreach (slot_ptr[i]) slot_ptr[i] = '0;
      full_q    = '0;
      lock_q    = '0;
      wr_pos    = '0;
      rd_pos    = '0;
      ring_size = RingSizeW'(RingSizeReset);
      errors    = 0;
    endfunction

    // zero acts as one slot, oversize values clamp to the full ring
    function int unsigned active_slots();
      if (ring_size == 0) return 1;
      if (ring_size > MaxSlotsDef) return MaxSlotsDef;
      return ring_size;
    endfunction

    function logic [IndexW-1:0] step_pos(logic [IndexW-1:0] pos);
      int unsigned nxt;
      nxt = pos + 1;
      if (nxt >= active_slots() || nxt >= MaxSlotsDef) nxt = 0;
      return nxt[IndexW-1:0];
    endfunction

    function void apply_request(logic [ReqW-1:0] req, logic [IndexW-1:0] idx,
                                logic [PtrW-1:0] val);
      ring_result_t r;
      int unsigned  rd;
      int unsigned  wr;
      r.status = ST_OK;
      r.ptr    = '0;
      rd = 0;
      wr = 0;
      case (req)
        REQ_LOAD: begin
          slot_ptr[idx] = val;
          full_q[idx]   = 1'b0;
          lock_q[idx]   = 1'b0;
          wr_pos        = '0;
          rd_pos        = '0;
        end
        REQ_WR_CLAIM: begin
          if (full_q[wr_pos]) r.status = ST_FULL;
          else if (lock_q[wr_pos]) r.status = ST_LOCKED;
          else begin
            lock_q[wr_pos] = 1'b1;
            r.ptr = slot_ptr[wr_pos];
          end
        end
        REQ_WR_COMMIT: begin
          if (!lock_q[wr_pos]) r.status = ST_NOT_LOCKED;
          else begin
            full_q[wr_pos] = 1'b1;
            lock_q[wr_pos] = 1'b0;
            wr_pos = step_pos(wr_pos);
          end
        end
        REQ_WR_CANCEL: begin
          if (!lock_q[wr_pos]) r.status = ST_NOT_LOCKED;
          else lock_q[wr_pos] = 1'b0;
        end
        REQ_RD_CLAIM: begin
          if (!full_q[rd_pos]) r.status = ST_EMPTY;
          else if (lock_q[rd_pos]) r.status = ST_LOCKED;
          else begin
            lock_q[rd_pos] = 1'b1;
            r.ptr = slot_ptr[rd_pos];
          end
        end
        REQ_RD_RELEASE: begin
          if (!lock_q[rd_pos]) r.status = ST_NOT_LOCKED;
          else begin
            full_q[rd_pos] = 1'b0;
            lock_q[rd_pos] = 1'b0;
            rd_pos = step_pos(rd_pos);
          end
        end
        REQ_RD_CANCEL: begin
          if (!lock_q[rd_pos]) r.status = ST_NOT_LOCKED;
          else lock_q[rd_pos] = 1'b0;
        end
        default: ;
      endcase
      for (int unsigned i = 0; i < active_slots(); i++) begin
        if (!lock_q[i]) begin
          if (full_q[i]) rd++;
          else wr++;
        end
      end
      r.readable = CountW'(rd);
      r.writable = CountW'(wr);
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [PtrW-1:0] got, logic [PtrW-1:0] want);
      errors++;
      if (errors <= 100)
        $display("%0t ring result %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_result(logic [StatusW-1:0] st, logic [PtrW-1:0] ptr,
                      logic [CountW-1:0] rd, logic [CountW-1:0] wr);
      ring_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("without request", {29'd0, st}, '0);
        return;
      end
      w = pending.pop_front();
      if (st !== w.status) report_mismatch("status", st, w.status);
      if (ptr !== w.ptr) report_mismatch("buffer_pointer", ptr, w.ptr);
      if (rd !== w.readable) report_mismatch("readable_count", rd, w.readable);
      if (wr !== w.writable) report_mismatch("writable_count", wr, w.writable);
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ReqW-1:0]        req_type_i = '0;
  logic [IndexW-1:0]      slot_index_i = '0;
  logic [PtrW-1:0]        pointer_value_i = '0;
  logic                   done_o;
  logic [StatusW-1:0]     status_o;
  logic [PtrW-1:0]        buffer_pointer_o;
  logic [CountW-1:0]      readable_count_o;
  logic [CountW-1:0]      writable_count_o;
  logic                   ring_size_we_i = 1'b0;
  logic [RingSizeW-1:0]   ring_size_i = '0;
  int unsigned            cycle_count = 0;
  ring_claim_model        model;

  buffer_pointer_ring_with_claims i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .slot_index_i     (slot_index_i),
    .pointer_value_i  (pointer_value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .buffer_pointer_o (buffer_pointer_o),
    .readable_count_o (readable_count_o),
    .writable_count_o (writable_count_o),
    .ring_size_we_i   (ring_size_we_i),
    .ring_size_i      (ring_size_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("buffer_pointer_ring_with_claims: mismatch");
      $finish;
    end
  end

  // every result strobe is one transfer, no back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      model.check_result(status_o, buffer_pointer_o, readable_count_o, writable_count_o);
  end

  task automatic issue(logic [ReqW-1:0] req, logic [IndexW-1:0] idx,
                       logic [PtrW-1:0] val, bit may_idle);
    start           <= 1'b1;
    req_type_i      <= req;
    slot_index_i    <= idx;
    pointer_value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model.apply_request(req, idx, val);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // only written with nothing in flight; the block recounts afterwards
  task automatic write_ring_size(logic [RingSizeW-1:0] size_val);
    start <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    ring_size_we_i <= 1'b1;
    ring_size_i    <= size_val;
    @(posedge clk_i);
    ring_size_we_i <= 1'b0;
    model.ring_size = size_val;
  endtask

  // mostly claim/commit and claim/release pairs, with some noise and reloads
  task automatic issue_random(bit may_idle);
    logic [ReqW-1:0]   req;
    logic [IndexW-1:0] idx;
    logic [PtrW-1:0]   val;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    idx  = IndexW'($urandom_range(0, MaxSlotsDef - 1));
    case ($urandom_range(0, 3))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom();
    endcase
    if (roll < 3) begin
      req = REQ_LOAD;
    end else if (roll < 10) begin
      req = ReqW'($urandom_range(0, 7));
    end else if (roll < 55) begin
      if (model.lock_q[model.wr_pos] && !model.full_q[model.wr_pos])
        req = ($urandom_range(0, 4) == 0) ? REQ_WR_CANCEL : REQ_WR_COMMIT;
      else
        req = REQ_WR_CLAIM;
    end else begin
      if (model.lock_q[model.rd_pos] && model.full_q[model.rd_pos])
        req = ($urandom_range(0, 4) == 0) ? REQ_RD_CANCEL : REQ_RD_RELEASE;
      else
        req = REQ_RD_CLAIM;
    end
    issue(req, idx, val, may_idle);
  endtask

  initial begin
    logic [RingSizeW-1:0] ring_plan [NumPhases];
    bit                   idle_on;
    model = new();
    ring_plan = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd5, 5'd2, 5'd17, 5'd12, 5'd3, 5'd16};
    ring_plan[7] = RingSizeW'($urandom_range(1, MaxSlotsDef));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot gets a pointer before any claim can read it
    for (int i = 0; i < MaxSlotsDef; i++) begin
      if (i == 0) issue(REQ_LOAD, IndexW'(i), '0, 1'b1);
      else if (i == MaxSlotsDef - 1) issue(REQ_LOAD, IndexW'(i), '1, 1'b1);
      else if (i % 2 == 1) issue(REQ_LOAD, IndexW'(i), 32'hA5A5_0000 | i, 1'b1);
      else issue(REQ_LOAD, IndexW'(i), 32'h5A5A_FF00 | i, 1'b1);
    end
    issue(REQ_WR_CANCEL, '0, '0, 1'b0);
    issue(REQ_WR_CLAIM, '0, '0, 1'b0);
    issue(REQ_WR_CLAIM, '0, '0, 1'b0);
    issue(REQ_RD_CLAIM, '0, '0, 1'b0);
    // reader cancel drops the writer's lock on the shared slot
    issue(REQ_RD_CANCEL, '0, '0, 1'b0);
    issue(REQ_WR_CLAIM, '0, '0, 1'b0);
    issue(REQ_WR_COMMIT, '0, '0, 1'b0);
    issue(REQ_RD_CLAIM, '0, '0, 1'b0);
    issue(REQ_RD_CLAIM, '0, '0, 1'b0);
    issue(REQ_RD_RELEASE, '0, '0, 1'b0);
    issue(REQ_RD_RELEASE, '0, '0, 1'b0);
    issue(ReqUnused, '1, '1, 1'b0);
    issue(REQ_WR_COMMIT, '0, '0, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      write_ring_size(ring_plan[p]);
      idle_on = (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PhaseItems; n++) issue_random(idle_on);
    end

    start <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (model.errors == 0 && model.pending.size() == 0)
      $display("buffer_pointer_ring_with_claims: match");
    else
      $display("buffer_pointer_ring_with_claims: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bprc_pkg.sv
rtl/bprc_ptr_mem.sv
rtl/bprc_ctrl.sv
rtl/buffer_pointer_ring_with_claims.sv
rtl/bprc_checker.sv
tb/buffer_pointer_ring_with_claims_tb.sv
